// ----- rtl/bba_pkg.sv -----
// ============================================================================
// Buddy allocator package
// Shared constants, types, datapath operations and controller states.
// ============================================================================
`default_nettype none

package bba_pkg;

    // Pool geometry.
    localparam int POOL_ORDER      = 16;
    localparam int MIN_BLOCK_ORDER = 4;
    localparam int LEVELS          = POOL_ORDER - MIN_BLOCK_ORDER;
    localparam int NORD            = LEVELS + 1;
    localparam int NODE_W          = LEVELS + 1;
    localparam int NODES           = 1 << NODE_W;
    localparam int SLOT_W          = LEVELS;
    localparam int SLOTS           = 1 << SLOT_W;
    localparam int ORD_W           = 5;

    // Field widths.
    localparam int REQ_W   = 20;
    localparam int OFF_W   = 16;
    localparam int USED_W  = 17;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 6;

    typedef logic [NORD-1:0]   t_mask;
    typedef logic [NODE_W-1:0] t_node;
    typedef logic [ORD_W-1:0]  t_ord;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FAIL    = 2'd1,
        STAT_IGNORED = 2'd2
    } t_status;

    // Operations that the controller issues to the datapath, one per cycle.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_RD_ROOT,
        OP_PICK,
        OP_RD_LEFT,
        OP_DESCEND,
        OP_SPLIT,
        OP_MARK,
        OP_FAIL,
        OP_RD_SLOT,
        OP_IGNORE,
        OP_F_TAKE,
        OP_RD_SIB,
        OP_MERGE,
        OP_SET,
        OP_UP
    } t_op;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic clr_last;
        logic is_free_op;
        logic too_big;
        logic bad_offset;
        logic pick_none;
        logic at_goal;
        logic at_target;
        logic at_root;
        logic ord_top;
        logic slot_empty;
        logic sib_free;
    } t_dp_stat;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_A_PICK,
        ST_A_CHK,
        ST_A_DESC,
        ST_A_SPLIT,
        ST_F_SLOT,
        ST_F_CHK,
        ST_F_SIB,
        ST_UP_CHK,
        ST_UP,
        ST_DONE
    } t_state;

    // Mask with the bit for the given block order set.
    function automatic t_mask ord_bit(input t_ord ord);
        t_mask one;
        one = t_mask'(1);
        return one << (ord - t_ord'(MIN_BLOCK_ORDER));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bba_datapath.sv -----
// ============================================================================
// Buddy allocator datapath
// Holds the per-node order masks, the live order table, the byte total and
// the walk registers, and executes one controller operation per cycle.
// ============================================================================
`default_nettype none

module bba_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bba_pkg::t_op               i_op,
    input  wire logic                       i_func,
    input  wire logic [bba_pkg::REQ_W-1:0]  i_request_bytes,
    input  wire logic [bba_pkg::OFF_W-1:0]  i_block_offset,
    output bba_pkg::t_dp_stat               o_stat,
    output logic [bba_pkg::STAT_W-1:0]      o_status,
    output logic [bba_pkg::OFF_W-1:0]       o_granted_offset,
    output logic [bba_pkg::USED_W-1:0]      o_bytes_in_use
);
    import bba_pkg::*;

    // Each node holds a mask of the free block orders found in its subtree.
    t_mask                mask_mem [NODES];
    logic [ENTRY_W-1:0]   table_mem [SLOTS];

    logic                 r_func;
    logic [OFF_W-1:0]     r_offset;
    logic                 r_too_big;
    t_ord                 r_target;
    t_ord                 r_goal;
    t_ord                 r_ord;
    t_node                r_node;
    t_mask                r_cur;
    t_mask                r_mask_q;
    logic [ENTRY_W-1:0]   r_tab_q;
    logic [USED_W-1:0]    r_used;
    logic [NODE_W-1:0]    r_clr;
    t_status              r_status;
    logic [OFF_W-1:0]     r_grant;

    t_ord                 ld_target;
    logic                 ld_too_big;
    logic [REQ_W-1:0]     size_m1;
    t_mask                avail;
    t_ord                 pick_ord;
    t_mask                sib_sh;
    t_mask                goal_sh;
    logic [NODE_W+POOL_ORDER-1:0] wide_off;
    logic [OFF_W-1:0]     grant_off;
    logic [OFF_W:0]       free_v;
    logic [OFF_W:0]       free_sh;
    t_ord                 free_ord;
    t_node                free_node;
    t_mask                up_mask;

    logic                 mw_en;
    t_node                mw_addr;
    t_mask                mw_data;
    logic                 mr_en;
    t_node                mr_addr;
    logic                 tw_en;
    logic [SLOT_W-1:0]    tw_addr;
    logic [ENTRY_W-1:0]   tw_data;
    logic                 tr_en;

    // Target order: the size rounded up to a power of two, at least the minimum.
    always_comb begin
        size_m1 = i_request_bytes - REQ_W'(1);
        ld_target = t_ord'(MIN_BLOCK_ORDER);
        if (32'(i_request_bytes) > (32'd1 << MIN_BLOCK_ORDER)) begin
            for (int i = 0; i < REQ_W; i++) begin
                if (size_m1[i]) begin
                    ld_target = t_ord'(i + 1);
                end
            end
        end
        ld_too_big = 32'(i_request_bytes) > (32'd1 << POOL_ORDER);
    end

    // Lowest order at or above the target that is free somewhere in the pool.
    always_comb begin
        avail    = r_mask_q & ~(ord_bit(r_target) - t_mask'(1));
        pick_ord = t_ord'(MIN_BLOCK_ORDER);
        for (int i = NORD - 1; i >= 0; i--) begin
            if (avail[i]) begin
                pick_ord = t_ord'(MIN_BLOCK_ORDER + i);
            end
        end
    end

    // Address arithmetic for grants and frees.
    always_comb begin
        sib_sh    = r_mask_q >> (r_ord - t_ord'(MIN_BLOCK_ORDER));
        goal_sh   = r_mask_q >> (r_goal - t_ord'(MIN_BLOCK_ORDER));
        wide_off  = {{POOL_ORDER{1'b0}}, r_node} << r_ord;
        grant_off = wide_off[OFF_W-1:0];
        free_ord  = r_tab_q[ORD_W-1:0] - t_ord'(1);
        free_v    = {1'b1, r_offset};
        free_sh   = free_v >> free_ord;
        free_node = free_sh[NODE_W-1:0];
        up_mask   = r_cur | r_mask_q;
    end

    // Memory port control for each operation.
    always_comb begin
        mw_en   = 1'b0;
        mw_addr = r_node;
        mw_data = '0;
        mr_en   = 1'b0;
        mr_addr = r_node;
        tw_en   = 1'b0;
        tw_addr = r_offset[OFF_W-1:MIN_BLOCK_ORDER];
        tw_data = '0;
        tr_en   = 1'b0;
        unique case (i_op)
            OP_CLEAR: begin
                mw_en   = 1'b1;
                mw_addr = r_clr;
                mw_data = (r_clr == t_node'(1)) ? ord_bit(t_ord'(POOL_ORDER)) : '0;
                tw_en   = ~r_clr[NODE_W-1];
                tw_addr = r_clr[SLOT_W-1:0];
            end
            OP_RD_ROOT: begin
                mr_en   = 1'b1;
                mr_addr = t_node'(1);
            end
            OP_RD_LEFT: begin
                mr_en   = 1'b1;
                mr_addr = {r_node[NODE_W-2:0], 1'b0};
            end
            OP_SPLIT: begin
                mw_en   = 1'b1;
                mw_addr = {r_node[NODE_W-2:0], 1'b1};
                mw_data = ord_bit(r_ord - t_ord'(1));
            end
            OP_MARK: begin
                mw_en   = 1'b1;
                tw_en   = 1'b1;
                tw_addr = grant_off[OFF_W-1:MIN_BLOCK_ORDER];
                tw_data = ENTRY_W'(r_target) + ENTRY_W'(1);
            end
            OP_RD_SLOT: begin
                tr_en   = 1'b1;
            end
            OP_F_TAKE: begin
                tw_en   = 1'b1;
            end
            OP_RD_SIB: begin
                mr_en   = 1'b1;
                mr_addr = r_node ^ t_node'(1);
            end
            OP_MERGE: begin
                mw_en   = 1'b1;
                mw_addr = r_node ^ t_node'(1);
            end
            OP_SET: begin
                mw_en   = 1'b1;
                mw_data = ord_bit(r_ord);
            end
            OP_UP: begin
                mw_en   = 1'b1;
                mw_addr = r_node >> 1;
                mw_data = up_mask;
            end
            default: begin
            end
        endcase
    end

    // Node mask memory.
    always_ff @(posedge i_clk) begin
        if (mw_en) begin
            mask_mem[mw_addr] <= mw_data;
        end
        if (mr_en) begin
            r_mask_q <= mask_mem[mr_addr];
        end
    end

    // Live order table memory.
    always_ff @(posedge i_clk) begin
        if (tw_en) begin
            table_mem[tw_addr] <= tw_data;
        end
        if (tr_en) begin
            r_tab_q <= table_mem[r_offset[OFF_W-1:MIN_BLOCK_ORDER]];
        end
    end

    // Control registers: clearing sweep counter and byte total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_used <= '0;
        end else begin
            if (i_op == OP_CLEAR) begin
                r_clr <= r_clr + NODE_W'(1);
            end
            if (i_op == OP_MARK) begin
                r_used <= r_used + (USED_W'(1) << r_target);
            end else if (i_op == OP_F_TAKE) begin
                r_used <= r_used - (USED_W'(1) << free_ord);
            end
        end
    end

    // Walk and result registers.
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_func    <= i_func;
                r_offset  <= i_block_offset;
                r_target  <= ld_target;
                r_too_big <= ld_too_big;
            end
            OP_RD_ROOT: begin
                r_node <= t_node'(1);
                r_ord  <= t_ord'(POOL_ORDER);
            end
            OP_PICK: begin
                r_goal <= pick_ord;
            end
            OP_DESCEND: begin
                // Go left when the left child has a free block of the goal order.
                r_node <= {r_node[NODE_W-2:0], ~goal_sh[0] ? 1'b1 : 1'b0};
                r_ord  <= r_ord - t_ord'(1);
            end
            OP_SPLIT: begin
                r_node <= {r_node[NODE_W-2:0], 1'b0};
                r_ord  <= r_ord - t_ord'(1);
            end
            OP_MARK: begin
                r_cur    <= '0;
                r_status <= STAT_OK;
                r_grant  <= grant_off;
            end
            OP_FAIL: begin
                r_status <= STAT_FAIL;
                r_grant  <= '0;
            end
            OP_IGNORE: begin
                r_status <= STAT_IGNORED;
                r_grant  <= '0;
            end
            OP_F_TAKE: begin
                r_node   <= free_node;
                r_ord    <= free_ord;
                r_status <= STAT_OK;
                r_grant  <= '0;
            end
            OP_MERGE: begin
                r_node <= r_node >> 1;
                r_ord  <= r_ord + t_ord'(1);
            end
            OP_SET: begin
                r_cur <= ord_bit(r_ord);
            end
            OP_UP: begin
                r_cur  <= up_mask;
                r_node <= r_node >> 1;
            end
            default: begin
            end
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_stat.clr_last   = &r_clr;
        o_stat.is_free_op = r_func;
        o_stat.too_big    = r_too_big;
        o_stat.bad_offset = |r_offset[MIN_BLOCK_ORDER-1:0];
        o_stat.pick_none  = ~|avail;
        o_stat.at_goal    = (r_ord == r_goal);
        o_stat.at_target  = (r_ord == r_target);
        o_stat.at_root    = (r_node == t_node'(1));
        o_stat.ord_top    = (r_ord == t_ord'(POOL_ORDER));
        o_stat.slot_empty = (r_tab_q == '0);
        o_stat.sib_free   = sib_sh[0];
    end

    assign o_status         = r_status;
    assign o_granted_offset = r_grant;
    assign o_bytes_in_use   = r_used;

endmodule

`default_nettype wire

// ----- rtl/bba_ctrl.sv -----
// ============================================================================
// Buddy allocator controller
// Sequences the clearing sweep, the search, split, merge and mask update
// walks, and the result strobe.
// ============================================================================
`default_nettype none

module bba_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire bba_pkg::t_dp_stat  i_stat,
    output bba_pkg::t_op            o_op,
    output logic                    busy,
    output logic                    o_done
);
    import bba_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:   if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE:    if (start) n_state = ST_DECODE;
            ST_DECODE: begin
                if (i_stat.is_free_op) begin
                    n_state = i_stat.bad_offset ? ST_DONE : ST_F_SLOT;
                end else begin
                    n_state = i_stat.too_big ? ST_DONE : ST_A_PICK;
                end
            end
            ST_A_PICK:  n_state = i_stat.pick_none ? ST_DONE : ST_A_CHK;
            ST_A_CHK: begin
                if (!i_stat.at_goal) begin
                    n_state = ST_A_DESC;
                end else if (i_stat.at_target) begin
                    n_state = ST_UP_CHK;
                end else begin
                    n_state = ST_A_SPLIT;
                end
            end
            ST_A_DESC:  n_state = ST_A_CHK;
            ST_A_SPLIT: if (i_stat.at_target) n_state = ST_UP_CHK;
            ST_F_SLOT:  n_state = i_stat.slot_empty ? ST_DONE : ST_F_CHK;
            ST_F_CHK:   n_state = i_stat.ord_top ? ST_UP_CHK : ST_F_SIB;
            ST_F_SIB:   n_state = i_stat.sib_free ? ST_F_CHK : ST_UP_CHK;
            ST_UP_CHK:  n_state = i_stat.at_root ? ST_DONE : ST_UP;
            ST_UP:      n_state = ST_UP_CHK;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_CLEAR;
        endcase
    end

    // Datapath operation for the current state.
    always_comb begin
        o_op = OP_NOP;
        unique case (r_state)
            ST_CLEAR:   o_op = OP_CLEAR;
            ST_IDLE:    if (start) o_op = OP_LOAD;
            ST_DECODE: begin
                if (i_stat.is_free_op) begin
                    o_op = i_stat.bad_offset ? OP_IGNORE : OP_RD_SLOT;
                end else begin
                    o_op = i_stat.too_big ? OP_FAIL : OP_RD_ROOT;
                end
            end
            ST_A_PICK:  o_op = i_stat.pick_none ? OP_FAIL : OP_PICK;
            ST_A_CHK: begin
                if (!i_stat.at_goal) begin
                    o_op = OP_RD_LEFT;
                end else begin
                    o_op = i_stat.at_target ? OP_MARK : OP_SPLIT;
                end
            end
            ST_A_DESC:  o_op = OP_DESCEND;
            ST_A_SPLIT: o_op = i_stat.at_target ? OP_MARK : OP_SPLIT;
            ST_F_SLOT:  o_op = i_stat.slot_empty ? OP_IGNORE : OP_F_TAKE;
            ST_F_CHK:   o_op = i_stat.ord_top ? OP_SET : OP_RD_SIB;
            ST_F_SIB:   o_op = i_stat.sib_free ? OP_MERGE : OP_SET;
            ST_UP_CHK:  o_op = i_stat.at_root ? OP_NOP : OP_RD_SIB;
            ST_UP:      o_op = OP_UP;
            default:    o_op = OP_NOP;
        endcase
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

`default_nettype wire

// ----- rtl/buddy_block_allocator.sv -----
// The block takes one request at a time. The walks are set by the single read
// and write port of the node mask memory. After reset the block sweeps the mask
// and order memories with busy high; results cannot be stalled.
// ============================================================================
// Buddy block allocator
// Power-of-two pool allocator with per-node free order masks and a live
// block order table; one result strobe per request.
// ============================================================================
`default_nettype none

module buddy_block_allocator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_func,
    input  wire logic [bba_pkg::REQ_W-1:0]  i_request_bytes,
    input  wire logic [bba_pkg::OFF_W-1:0]  i_block_offset,
    output logic                            o_done,
    output logic [bba_pkg::STAT_W-1:0]      o_status,
    output logic [bba_pkg::OFF_W-1:0]       o_granted_offset,
    output logic [bba_pkg::USED_W-1:0]      o_bytes_in_use
);
    import bba_pkg::*;

    t_op      op;
    t_dp_stat stat;

    // Sequencing of each request.
    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_op    (op),
        .busy    (busy),
        .o_done  (o_done)
    );

    // Storage and arithmetic.
    bba_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_func           (i_func),
        .i_request_bytes  (i_request_bytes),
        .i_block_offset   (i_block_offset),
        .o_stat           (stat),
        .o_status         (o_status),
        .o_granted_offset (o_granted_offset),
        .o_bytes_in_use   (o_bytes_in_use)
    );

endmodule

`default_nettype wire

// ----- rtl/bba_checker.sv -----
// ============================================================================
// Buddy allocator port checker
// Checks the request and result behavior seen on the top level ports.
// ============================================================================
`default_nettype none

module bba_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_done,
    input wire logic [bba_pkg::STAT_W-1:0] o_status,
    input wire logic [bba_pkg::OFF_W-1:0]  o_granted_offset,
    input wire logic [bba_pkg::USED_W-1:0] o_bytes_in_use
);
    import bba_pkg::*;

    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted request");

    // The result strobe lasts one cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // Failed or ignored requests report a zero offset.
    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != STAT_OK |-> o_granted_offset == '0)
        else $error("nonzero offset on a request that was not granted");

    // At each result strobe the total does not exceed the pool and the status code is defined.
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_bytes_in_use <= (USED_W'(1) << POOL_ORDER)) &&
                   (o_status == STAT_OK || o_status == STAT_FAIL ||
                    o_status == STAT_IGNORED))
        else $error("byte total or status out of range");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_status         (o_status),
    .o_granted_offset (o_granted_offset),
    .o_bytes_in_use   (o_bytes_in_use)
);

`default_nettype wire
